[rtl/core/lssu_pkg.sv]
// package for the log-structured sector store: sizes, tag constant, search token
// no dependencies
package lssu_pkg;

    localparam int WORDS_PER_SECTOR = 128;
    localparam int LOG_SLOTS        = 256;
    localparam int SLOT_W           = $clog2(LOG_SLOTS);
    localparam int WORD_W           = $clog2(WORDS_PER_SECTOR);
    localparam int USED_W           = $clog2(LOG_SLOTS + 1);
    localparam int LOG_AW           = SLOT_W + WORD_W;
    localparam logic [31:0] FREE_TAG = 32'hFFFF_FFFF;

    typedef struct packed {
        logic              valid;
        logic [31:0]       key;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } query_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       tag;
    } tag_wr_t;

endpackage

[rtl/core/lssu_cell.sv]
// one tag cell: holds the tag of one log slot and passes the search token on
// depends on lssu_pkg
module lssu_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [lssu_pkg::SLOT_W-1:0] cell_idx,
    input  lssu_pkg::tag_wr_t      tag_wr,
    input  lssu_pkg::query_t       q_in,
    output lssu_pkg::query_t       q_out
);
    import lssu_pkg::*;

    logic [31:0] tag_reg;
    logic        used_reg;
    query_t      q_reg;
    query_t      q_next;

    always_comb
    begin
        q_next = q_in;
        if (q_in.valid && used_reg && (tag_reg == q_in.key))
        begin
            q_next.hit  = 1'b1;
            q_next.slot = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            q_reg    <= '0;
        end
        else
        begin
            q_reg <= q_next;
            if (tag_wr.en && (tag_wr.slot == cell_idx))
                used_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_wr.en && (tag_wr.slot == cell_idx))
            tag_reg <= tag_wr.tag;
    end

    assign q_out = q_reg;

endmodule

[rtl/core/lssu_chain.sv]
// row of tag cells; a search token walks one cell per cycle, newest match wins
// depends on lssu_pkg, lssu_cell
module lssu_chain (
    input  logic              clk,
    input  logic              rst_n,
    input  lssu_pkg::tag_wr_t tag_wr,
    input  lssu_pkg::query_t  q_in,
    output lssu_pkg::query_t  q_out
);
    import lssu_pkg::*;

    query_t link [0:LOG_SLOTS];

    assign link[0] = q_in;

    for (genvar i = 0; i < LOG_SLOTS; i++)
    begin : g_cell
        lssu_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (SLOT_W'(i)),
            .tag_wr   (tag_wr),
            .q_in     (link[i]),
            .q_out    (link[i+1])
        );
    end

    assign q_out = link[LOG_SLOTS];

endmodule

[rtl/core/log_structured_sector_store_unit.sv]
// log-structured sector store, top level: control, sector log and staging memories
// depends on lssu_pkg, lssu_chain
//
// input channel s_*: one transfer per request; s_tuser is the request kind
// (0 read one word, 1 write one word), s_tdata carries address, index, data.
// output channel m_*: one transfer per read and per final-word write.
// one request is in work at a time; s_tready is high only while idle.
// non-final write word: no result.
// read, same block as the previous lookup: no search; ST_RD (on a hit), then ST_RESP.
// read, other block: ST_SCAN while the search token walks the tag cell row one cell
// per cycle, then ST_RD (on a hit) and ST_RESP.
// final write that appends: ST_COPY copies the staging memory to the log memory
// one word a cycle, then ST_RESP.
// refused or dropped final write: straight to ST_RESP.
// reset empties the log (fill count and cell valid bits clear at once, no
// clearing pass); the staging memory is not cleared.
// a stalled receiver holds the result register; the block then waits before
// its next result but keeps accepting write words that give no result.
module log_structured_sector_store_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // block_addr[31:0], word_index[38:32], write_data[70:39], zero
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data
    output logic [1:0]  m_tuser    // status, write_done
);
    import lssu_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_RESP = 3'd3;
    localparam logic [2:0] ST_COPY = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic              nz_reg, nz_next;
    logic              cache_ok_reg, cache_ok_next;
    logic [31:0]       cache_addr_reg, cache_addr_next;
    logic              cache_hit_reg, cache_hit_next;
    logic [SLOT_W-1:0] cache_slot_reg, cache_slot_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [WORD_W-1:0] ridx_reg, ridx_next;
    logic [WORD_W:0]   cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [WORD_W-1:0] widx_reg, widx_next;
    logic              r_mem_reg, r_mem_next;
    logic              r_status_reg, r_status_next;
    logic              r_done_reg, r_done_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_data_reg, m_data_next;
    logic [1:0]        m_user_reg, m_user_next;

    logic [31:0] log_mem [0:LOG_SLOTS*WORDS_PER_SECTOR-1];
    logic [31:0] stage_mem [0:WORDS_PER_SECTOR-1];
    logic [31:0] log_rdata_reg;
    logic [31:0] st_rdata_reg;

    logic              accept;
    logic [31:0]       in_addr;
    logic [6:0]        in_idx;
    logic [31:0]       in_data;
    logic              full;
    logic              idx_ok;
    logic              idx_last;
    logic [WORD_W-1:0] idx_w;
    logic              st_we;
    logic              log_we;
    logic [LOG_AW-1:0] log_waddr;
    logic [LOG_AW-1:0] log_raddr;
    tag_wr_t           tag_wr;
    query_t            q_in;
    query_t            q_out;

    assign in_addr  = s_tdata[31:0];
    assign in_idx   = s_tdata[38:32];
    assign in_data  = s_tdata[70:39];
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign full     = (used_reg == USED_W'(LOG_SLOTS));
    assign idx_ok   = (32'(in_idx) < 32'(WORDS_PER_SECTOR));
    assign idx_last = (32'(in_idx) == 32'(WORDS_PER_SECTOR - 1));
    assign idx_w    = WORD_W'(32'(in_idx));
    assign st_we    = accept && s_tuser && idx_ok;

    assign log_we    = (state_reg == ST_COPY) && pend_reg;
    assign log_waddr = {used_reg[SLOT_W-1:0], widx_reg};
    assign log_raddr = {slot_reg, ridx_reg};

    lssu_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag_wr (tag_wr),
        .q_in   (q_in),
        .q_out  (q_out)
    );

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        nz_next         = nz_reg;
        cache_ok_next   = cache_ok_reg;
        cache_addr_next = cache_addr_reg;
        cache_hit_next  = cache_hit_reg;
        cache_slot_next = cache_slot_reg;
        slot_next       = slot_reg;
        ridx_next       = ridx_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        widx_next       = widx_reg;
        r_mem_next      = r_mem_reg;
        r_status_next   = r_status_reg;
        r_done_next     = r_done_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        q_in            = '0;
        tag_wr          = '0;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !s_tuser)
                begin
                    ridx_next     = idx_w;
                    r_mem_next    = 1'b0;
                    r_done_next   = 1'b0;
                    r_status_next = full;
                    if (full || !idx_ok)
                        state_next = ST_RESP;
                    else if (cache_ok_reg && (cache_addr_reg == in_addr))
                    begin
                        slot_next  = cache_slot_reg;
                        state_next = cache_hit_reg ? ST_RD : ST_RESP;
                    end
                    else
                    begin
                        q_in.valid      = 1'b1;
                        q_in.key        = in_addr;
                        cache_addr_next = in_addr;
                        state_next      = ST_SCAN;
                    end
                end
                else if (accept && s_tuser && idx_ok)
                begin
                    if (in_data != 32'd0)
                        nz_next = 1'b1;
                    if (idx_last)
                    begin
                        nz_next       = 1'b0;
                        r_mem_next    = 1'b0;
                        r_done_next   = 1'b1;
                        r_status_next = full;
                        if (!full && (nz_reg || (in_data != 32'd0)) && (in_addr != FREE_TAG))
                        begin
                            cache_addr_next = in_addr;
                            cnt_next        = '0;
                            pend_next       = 1'b0;
                            state_next      = ST_COPY;
                        end
                        else
                            state_next = ST_RESP;
                    end
                end
            end
            ST_SCAN:
            begin
                if (q_out.valid)
                begin
                    cache_ok_next   = 1'b1;
                    cache_hit_next  = q_out.hit;
                    cache_slot_next = q_out.slot;
                    slot_next       = q_out.slot;
                    state_next      = q_out.hit ? ST_RD : ST_RESP;
                end
            end
            ST_RD:
            begin
                r_mem_next = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = r_mem_reg ? log_rdata_reg : 32'd0;
                    m_user_next  = {r_done_reg, r_status_reg};
                    state_next   = ST_IDLE;
                end
            end
            ST_COPY:
            begin
                if (cnt_reg < (WORD_W + 1)'(WORDS_PER_SECTOR))
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                    widx_next = cnt_reg[WORD_W-1:0];
                end
                else
                begin
                    pend_next     = 1'b0;
                    tag_wr.en     = 1'b1;
                    tag_wr.slot   = used_reg[SLOT_W-1:0];
                    tag_wr.tag    = cache_addr_reg;
                    used_next     = used_reg + 1'b1;
                    cache_ok_next = 1'b0;
                    state_next    = ST_RESP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            nz_reg       <= 1'b0;
            cache_ok_reg <= 1'b0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            nz_reg       <= nz_next;
            cache_ok_reg <= cache_ok_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cache_addr_reg <= cache_addr_next;
        cache_hit_reg  <= cache_hit_next;
        cache_slot_reg <= cache_slot_next;
        slot_reg       <= slot_next;
        ridx_reg       <= ridx_next;
        cnt_reg        <= cnt_next;
        widx_reg       <= widx_next;
        r_mem_reg      <= r_mem_next;
        r_status_reg   <= r_status_next;
        r_done_reg     <= r_done_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    always_ff @(posedge clk)
    begin
        if (log_we)
            log_mem[log_waddr] <= st_rdata_reg;
        log_rdata_reg <= log_mem[log_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            stage_mem[idx_w] <= in_data;
        st_rdata_reg <= stage_mem[cnt_reg[WORD_W-1:0]];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(LOG_SLOTS))
        else $error("fill count beyond log size");

    a_copy_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY) |-> !full)
        else $error("sector copy while log full");

    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        q_out.valid |-> (state_reg == ST_SCAN))
        else $error("search token left the row outside a scan");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        tag_wr.en |=> (used_reg == $past(used_reg) + 1'b1))
        else $error("append without fill count step");

endmodule
